>>> hdl/distance_transform_1d_assert.svh
`ifndef DISTANCE_TRANSFORM_1D_ASSERT_SVH
`define DISTANCE_TRANSFORM_1D_ASSERT_SVH

// cond holds in the same cycle as trig
`define DT1D_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// cond holds in the cycle after trig
`define DT1D_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> hdl/dt1d_pkg.sv
package dt1d_pkg;

    function automatic int max_i(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // row length limit and working width of sample values
    localparam int LEN_MAX    = 64;
    localparam int VALUE_BITS = 24;

    // fixed field widths on the ports
    localparam int VALUE_FIELD_W = 24;
    localparam int DIST_FIELD_W  = 24;
    localparam int POS_FIELD_W   = 6;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 32;
    localparam int OUT_PAD_W     = OUT_TDATA_W - DIST_FIELD_W - POS_FIELD_W;

    // internal widths
    localparam int POS_W  = $clog2(LEN_MAX);
    localparam int CNT_W  = POS_W + 1;
    localparam int SQ_W   = 2 * POS_W;
    localparam int F_W    = max_i(VALUE_BITS, SQ_W) + 1;
    localparam int NUM_W  = F_W + 1;
    localparam int DEN_W  = POS_W + 1;
    localparam int PRD_W  = NUM_W + DEN_W + 1;
    localparam int IN_W   = (VALUE_BITS < VALUE_FIELD_W) ? VALUE_BITS : VALUE_FIELD_W;

    // one envelope site with its lower boundary num/den
    typedef struct packed {
        logic        [POS_W-1:0]      site;
        logic        [VALUE_BITS-1:0] val;
        logic        [F_W-1:0]        f;
        logic signed [NUM_W-1:0]      num;
        logic        [DEN_W-1:0]      den;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'b00,
        CELL_DOWN = 2'b01,
        CELL_UP   = 2'b10
    } cell_op_t;

endpackage

>>> hdl/dt1d_cell.sv
module dt1d_cell
    import dt1d_pkg::*;
(
    input  logic     clk,
    input  cell_op_t op,
    input  entry_t   prev_entry,
    input  entry_t   next_entry,
    output entry_t   entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        case (op)
            CELL_DOWN: entry_next = prev_entry;
            CELL_UP:   entry_next = next_entry;
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> hdl/distance_transform_1d.sv
// channel | dir | beat fields
// s_*     | in  | tdata: value[23:0]; tlast: last sample of the row
// m_*     | out | tdata: distance[23:0], position[29:24]; tlast: last result
//
// a sample is taken in the accept state, then the compare state pops sites off the envelope
// chain until it pushes the new site; pops are bounded by pushes; no sample is taken meanwhile
// at row end the chain shifts its bottom site down to the far cell,
// then emits n results, shifting the chain down each time the walk moves to the next site
// reset clears control and the output valid; cell contents are not reset
// a stalled result holds in the output register; while the row's last result is stalled, the next row may start loading
module distance_transform_1d
    import dt1d_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // value
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // distance, position, zero pad
    output logic                   m_tlast
);

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_CMP   = 4'b0010,
        ST_ALIGN = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    localparam logic [POS_W-1:0]      LAST_IDX  = POS_W'(LEN_MAX - 1);
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [POS_W-1:0]        top_reg, top_next;
    logic [POS_W-1:0]        ptr_reg, ptr_next;
    logic                    last_reg;
    logic [VALUE_BITS-1:0]   in_val_reg;
    logic [F_W-1:0]          in_f_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [DIST_FIELD_W-1:0] out_dist_reg;
    logic [POS_FIELD_W-1:0]  out_pos_reg;
    logic                    out_last_reg;

    cell_op_t                op;
    entry_t                  cells [LEN_MAX];
    entry_t                  new_entry;

    logic                    in_fire;
    logic [VALUE_BITS-1:0]   in_val;
    logic [POS_W-1:0]        q;
    logic [SQ_W-1:0]         q_sq;

    logic signed [NUM_W-1:0] num_c;
    logic [DEN_W-1:0]        den_c;
    logic signed [PRD_W-1:0] lhs;
    logic signed [PRD_W-1:0] rhs;
    logic                    do_push;
    logic [POS_W-1:0]        push_top;
    logic                    row_end;

    logic [POS_W+DEN_W-1:0]  qd;
    logic                    adv;
    logic [POS_W-1:0]        dpos;
    logic [SQ_W-1:0]         dsq;
    logic [F_W-1:0]          dsum;
    logic [VALUE_BITS-1:0]   dist_sat;
    logic                    emit_last;
    logic                    out_free;
    logic                    out_load;

    assign q        = n_reg[POS_W-1:0];
    assign s_tready = (state_reg == ST_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign in_val   = VALUE_BITS'(s_tdata[IN_W-1:0]);
    assign q_sq     = SQ_W'(q) * SQ_W'(q);

    // push path: intersection of the new parabola with the top site
    assign num_c    = $signed({1'b0, in_f_reg}) - $signed({1'b0, cells[0].f});
    assign den_c    = {q - cells[0].site, 1'b0};
    assign lhs      = PRD_W'(num_c) * PRD_W'($signed({1'b0, cells[0].den}));
    assign rhs      = PRD_W'(cells[0].num) * PRD_W'($signed({1'b0, den_c}));
    assign do_push  = (q == '0) || (top_reg == '0) || (lhs > rhs);
    assign push_top = (q == '0) ? '0 : top_reg + POS_W'(1);
    assign row_end  = last_reg || ((n_reg + CNT_W'(1)) == CNT_W'(LEN_MAX));

    assign new_entry.site = q;
    assign new_entry.val  = in_val_reg;
    assign new_entry.f    = in_f_reg;
    assign new_entry.num  = num_c;
    assign new_entry.den  = den_c;

    // emit path: current site sits in the far cell, its successor one before
    assign qd       = (POS_W+DEN_W)'(ptr_reg) * (POS_W+DEN_W)'(cells[LEN_MAX-2].den);
    assign adv      = (top_reg != '0) &&
                      (PRD_W'(cells[LEN_MAX-2].num) < $signed(PRD_W'(qd)));
    assign dpos     = (ptr_reg >= cells[LEN_MAX-1].site) ? ptr_reg - cells[LEN_MAX-1].site
                                                        : cells[LEN_MAX-1].site - ptr_reg;
    assign dsq      = SQ_W'(dpos) * SQ_W'(dpos);
    assign dsum     = F_W'(cells[LEN_MAX-1].val) + F_W'(dsq);
    assign dist_sat = (dsum > F_W'(VALUE_MAX)) ? VALUE_MAX : dsum[VALUE_BITS-1:0];
    assign emit_last = ((CNT_W'(ptr_reg) + CNT_W'(1)) == n_reg);
    assign out_free = !out_valid_reg || m_tready;

    genvar gi;
    generate
        for (gi = 0; gi < LEN_MAX; gi++)
        begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            if (gi == 0)
            begin : g_head
                assign prev_e = new_entry;
            end
            else
            begin : g_body
                assign prev_e = cells[gi-1];
            end
            if (gi == LEN_MAX - 1)
            begin : g_tail
                assign next_e = cells[gi];
            end
            else
            begin : g_link
                assign next_e = cells[gi+1];
            end
            dt1d_cell u_cell (
                .clk        (clk),
                .op         (op),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .entry      (cells[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        top_next   = top_reg;
        ptr_next   = ptr_reg;
        op         = CELL_HOLD;
        out_load   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (do_push)
                begin
                    op       = CELL_DOWN;
                    top_next = push_top;
                    n_next   = n_reg + CNT_W'(1);
                    if (row_end)
                    begin
                        state_next = ST_ALIGN;
                        ptr_next   = push_top;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
                else
                begin
                    op       = CELL_UP;
                    top_next = top_reg - POS_W'(1);
                end
            end
            ST_ALIGN:
            begin
                // ptr tracks the cell holding the bottom site
                if (ptr_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT;
                    ptr_next   = '0;
                end
                else
                begin
                    op       = CELL_DOWN;
                    ptr_next = ptr_reg + POS_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (adv)
                begin
                    op       = CELL_DOWN;
                    top_next = top_reg - POS_W'(1);
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    if (emit_last)
                    begin
                        state_next = ST_LOAD;
                        n_next     = '0;
                        top_next   = '0;
                        ptr_next   = '0;
                    end
                    else
                    begin
                        ptr_next = ptr_reg + POS_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            n_reg         <= '0;
            top_reg       <= '0;
            ptr_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            top_reg       <= top_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
            if (in_fire)
            begin
                last_reg <= s_tlast;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_val_reg <= in_val;
            in_f_reg   <= F_W'(in_val) + F_W'(q_sq);
        end
        if (out_load)
        begin
            out_dist_reg <= DIST_FIELD_W'(dist_sat);
            out_pos_reg  <= POS_FIELD_W'(ptr_reg);
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_pos_reg, out_dist_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> hdl/dt1d_checker.sv
`include "distance_transform_1d_assert.svh"

module dt1d_checker
    import dt1d_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // a stalled result beat holds
    `DT1D_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed under stall")

    // every sample goes through the compare state before the next beat is taken
    `DT1D_ASSERT_NEXT(a_in_gap, s_tvalid && s_tready, !s_tready, "input taken on back-to-back cycles")

    // no new row is loaded while a result other than the last of the current row is pending
    `DT1D_ASSERT_NOW(a_no_load_mid_row, m_tvalid && !m_tlast, !s_tready, "input ready in the middle of a row")

    // the highest position ends a forced row
    `DT1D_ASSERT_NOW(a_max_pos_last, m_tvalid && (m_tdata[DIST_FIELD_W +: POS_FIELD_W] == POS_FIELD_W'(LEN_MAX - 1)), m_tlast, "highest position without last")

endmodule

bind distance_transform_1d dt1d_checker u_dt1d_checker (.*);
